### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("%m: check failed");

// A consequence that must hold in the same cycle as its cause.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

`endif

### rtl/som_pkg.sv
package som_pkg;

  localparam int LIMB_W = 32;
  localparam int NLIMB  = 8;

  localparam logic [2:0] FUNC_ADD = 3'd0;
  localparam logic [2:0] FUNC_SUB = 3'd1;
  localparam logic [2:0] FUNC_MUL = 3'd2;
  localparam logic [2:0] FUNC_NEG = 3'd3;
  localparam logic [2:0] FUNC_INV = 3'd4;
  localparam logic [2:0] FUNC_RED = 3'd5;

  // Group order n, 2^256 - n used to fold upper halves, and the inversion exponent n - 2.
  localparam logic [255:0] ORDER_N =
    256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEBAAEDCE6AF48A03BBFD25E8CD0364141;
  localparam logic [255:0] FOLD_C =
    256'h000000000000000000000000000000014551231950B75FC4402DA1732FC9BEBF;
  localparam logic [255:0] EXP_INV =
    256'hFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFFEBAAEDCE6AF48A03BBFD25E8CD036413F;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_NEG, OP_INV, OP_RED, OP_NONE
  } op_t;

  typedef struct packed {
    op_t          op;
    logic [255:0] x;
    logic [255:0] y;
  } q_entry_t;

endpackage

### rtl/som_if.sv
interface som_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [63:0] a_w3;
  logic [63:0] a_w2;
  logic [63:0] a_w1;
  logic [63:0] a_w0;
  logic [63:0] b_w3;
  logic [63:0] b_w2;
  logic [63:0] b_w1;
  logic [63:0] b_w0;

  modport source (output valid, func, a_w3, a_w2, a_w1, a_w0, b_w3, b_w2, b_w1, b_w0,
                  input ready);
  modport sink (input valid, func, a_w3, a_w2, a_w1, a_w0, b_w3, b_w2, b_w1, b_w0,
                output ready);
endinterface

interface som_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] r_w3;
  logic [63:0] r_w2;
  logic [63:0] r_w1;
  logic [63:0] r_w0;
  logic        valid_res;
  logic        is_zero;

  modport source (output valid, r_w3, r_w2, r_w1, r_w0, valid_res, is_zero, input ready);
  modport sink (input valid, r_w3, r_w2, r_w1, r_w0, valid_res, is_zero, output ready);
endinterface

### rtl/som_front.sv
module som_front (
  som_in_if.sink            in_s,
  input  logic              full,
  output logic              push,
  output som_pkg::q_entry_t push_data
);

  logic [255:0] a_raw;
  logic [255:0] b_raw;
  logic [256:0] a_dn;
  logic [256:0] b_dn;
  logic [255:0] a_red;
  logic [255:0] b_red;
  som_pkg::op_t op;

  assign a_raw = {in_s.a_w3, in_s.a_w2, in_s.a_w1, in_s.a_w0};
  assign b_raw = {in_s.b_w3, in_s.b_w2, in_s.b_w1, in_s.b_w0};

  // Any 256-bit value is below 2n, so one conditional subtract reduces it.
  assign a_dn  = {1'b0, a_raw} - {1'b0, som_pkg::ORDER_N};
  assign b_dn  = {1'b0, b_raw} - {1'b0, som_pkg::ORDER_N};
  assign a_red = a_dn[256] ? a_raw : a_dn[255:0];
  assign b_red = b_dn[256] ? b_raw : b_dn[255:0];

  always_comb begin
    unique case (in_s.func)
      som_pkg::FUNC_ADD: op = som_pkg::OP_ADD;
      som_pkg::FUNC_SUB: op = som_pkg::OP_SUB;
      som_pkg::FUNC_MUL: op = som_pkg::OP_MUL;
      som_pkg::FUNC_NEG: op = som_pkg::OP_NEG;
      som_pkg::FUNC_INV: op = som_pkg::OP_INV;
      som_pkg::FUNC_RED: op = som_pkg::OP_RED;
      default:           op = som_pkg::OP_NONE;
    endcase
  end

  // The wide reduction works on the raw 512-bit value.
  assign push_data.op = op;
  assign push_data.x  = (op == som_pkg::OP_RED) ? a_raw : a_red;
  assign push_data.y  = (op == som_pkg::OP_RED) ? b_raw : b_red;

  assign in_s.ready = !full;
  assign push       = in_s.valid && !full;

endmodule

### rtl/som_queue.sv
`include "assert_macros.svh"

module som_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  som_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output som_pkg::q_entry_t head,
  output logic              not_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  som_pkg::q_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= push_data;
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  `ASSERT_ALWAYS(a_q_count_bound, clk, rst_n, count_r <= CNT_W'(DEPTH))
  `ASSERT_IMPLY(a_q_empty_ptrs, clk, rst_n, count_r == '0, wr_ptr_r == rd_ptr_r)
  `ASSERT_IMPLY(a_q_no_push_full, clk, rst_n, full, !push)

endmodule

### rtl/som_back.sv
`include "assert_macros.svh"

module som_back (
  input  logic              clk,
  input  logic              rst_n,
  input  som_pkg::q_entry_t head,
  input  logic              not_empty,
  output logic              pop,
  som_out_if.source         out_s
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MAC, S_CHK, S_SUBN, S_FIN
  } state_t;

  state_t             state_r;
  som_pkg::op_t       op_r;
  logic [255:0]       x_r;
  logic [255:0]       y_r;
  logic               bad_r;
  logic               phase_r;
  logic [7:0]         bit_r;
  logic [15:0][31:0]  w_r;
  logic [7:0][31:0]   mx_r;
  logic [7:0][31:0]   my_r;
  logic [2:0]         mi_r;
  logic [2:0]         mj_r;
  logic [31:0]        carry_r;
  logic               out_v_r;
  logic [255:0]       r_r;
  logic               valid_res_r;
  logic               is_zero_r;

  logic [3:0]   idx;
  logic [3:0]   idx_hi;
  logic [63:0]  prod;
  logic [63:0]  mac_s;
  logic [255:0] w_lo;
  logic [256:0] sum_xy;
  logic [256:0] dn;
  logic [255:0] n_minus_x;
  logic [255:0] n_minus_y;
  logic         high_nz;
  logic         next_mul;
  logic         inv_last;
  logic         inv_more;
  logic         out_fire;

  // One 32x32 multiply-accumulate step of an operand-scanning product per cycle.
  assign idx    = {1'b0, mi_r} + {1'b0, mj_r};
  assign idx_hi = {1'b0, mi_r} + 4'd8;
  assign prod   = {32'b0, mx_r[mi_r]} * {32'b0, my_r[mj_r]};
  assign mac_s  = prod + {32'b0, w_r[idx]} + {32'b0, carry_r};

  assign w_lo      = w_r[7:0];
  assign sum_xy    = {1'b0, x_r} + {1'b0, y_r};
  assign dn        = {1'b0, w_lo} - {1'b0, som_pkg::ORDER_N};
  assign n_minus_x = som_pkg::ORDER_N - x_r;
  assign n_minus_y = som_pkg::ORDER_N - y_r;
  assign high_nz   = |w_r[15:8];

  // Square-and-multiply walk over the bits of n - 2, most significant first.
  assign next_mul = !phase_r && som_pkg::EXP_INV[bit_r];
  assign inv_last = !next_mul && (bit_r == 8'd0);
  assign inv_more = (op_r == som_pkg::OP_INV) && !bad_r && !inv_last;
  assign out_fire = (state_r == S_FIN) && !inv_more && (!out_v_r || out_s.ready);

  assign pop = (state_r == S_IDLE) && not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
    end else begin
      if (out_fire) begin
        out_v_r <= 1'b1;
      end else if (out_s.ready) begin
        out_v_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (not_empty) begin
            op_r    <= head.op;
            x_r     <= head.x;
            y_r     <= head.y;
            bad_r   <= 1'b0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          mi_r    <= '0;
          mj_r    <= '0;
          carry_r <= '0;
          phase_r <= 1'b0;
          bit_r   <= 8'd255;
          unique case (op_r)
            som_pkg::OP_ADD: begin
              w_r     <= 512'(sum_xy);
              state_r <= S_CHK;
            end
            som_pkg::OP_SUB: begin
              // a - b is carried out as a + (n - b).
              y_r  <= n_minus_y;
              op_r <= som_pkg::OP_ADD;
            end
            som_pkg::OP_MUL: begin
              w_r     <= '0;
              mx_r    <= x_r;
              my_r    <= y_r;
              state_r <= S_MAC;
            end
            som_pkg::OP_NEG: begin
              w_r     <= 512'(n_minus_x);
              state_r <= S_CHK;
            end
            som_pkg::OP_INV: begin
              w_r <= '0;
              if (x_r == '0) begin
                bad_r   <= 1'b1;
                state_r <= S_FIN;
              end else begin
                mx_r    <= 256'd1;
                my_r    <= 256'd1;
                state_r <= S_MAC;
              end
            end
            som_pkg::OP_RED: begin
              w_r     <= {x_r, y_r};
              state_r <= S_CHK;
            end
            default: begin
              w_r     <= '0;
              state_r <= S_FIN;
            end
          endcase
        end
        S_MAC: begin
          w_r[idx] <= mac_s[31:0];
          if (mj_r == 3'd7) begin
            w_r[idx_hi] <= mac_s[63:32];
            carry_r     <= '0;
            mj_r        <= '0;
            mi_r        <= mi_r + 3'd1;
            if (mi_r == 3'd7) begin
              state_r <= S_CHK;
            end
          end else begin
            carry_r <= mac_s[63:32];
            mj_r    <= mj_r + 3'd1;
          end
        end
        S_CHK: begin
          // Fold the upper half back in with 2^256 = c (mod n) until it is empty.
          if (high_nz) begin
            mx_r    <= w_r[15:8];
            my_r    <= som_pkg::FOLD_C;
            w_r     <= {256'b0, w_lo};
            mi_r    <= '0;
            mj_r    <= '0;
            carry_r <= '0;
            state_r <= S_MAC;
          end else begin
            state_r <= S_SUBN;
          end
        end
        S_SUBN: begin
          if (!dn[256]) begin
            w_r[7:0] <= dn[255:0];
          end else begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (inv_more) begin
            w_r     <= '0;
            mx_r    <= w_lo;
            mi_r    <= '0;
            mj_r    <= '0;
            carry_r <= '0;
            if (next_mul) begin
              phase_r <= 1'b1;
              my_r    <= x_r;
            end else begin
              phase_r <= 1'b0;
              my_r    <= w_lo;
              bit_r   <= bit_r - 8'd1;
            end
            state_r <= S_MAC;
          end else if (out_fire) begin
            r_r         <= w_lo;
            valid_res_r <= !bad_r;
            is_zero_r   <= (w_lo == '0);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_s.valid     = out_v_r;
  assign out_s.r_w3      = r_r[255:192];
  assign out_s.r_w2      = r_r[191:128];
  assign out_s.r_w1      = r_r[127:64];
  assign out_s.r_w0      = r_r[63:0];
  assign out_s.valid_res = valid_res_r;
  assign out_s.is_zero   = is_zero_r;

  `ASSERT_IMPLY(a_out_zero_flag, clk, rst_n, out_v_r, is_zero_r == (r_r == '0))
  `ASSERT_IMPLY(a_bad_inv_zero, clk, rst_n, out_v_r && !valid_res_r, is_zero_r)
  `ASSERT_IMPLY(a_subn_folded, clk, rst_n, state_r == S_SUBN, w_r[15:8] == '0)

endmodule

### rtl/scalar_mod_order_alu.sv
// Unused codes and failed inversions skip the arithmetic and give a zero result; every other
// result has its upper half folded back in until it is empty, then n is subtracted as needed.
// Multiply and each fold run on the single 32x32 multiply-accumulate unit; inversion runs about
// 450 modular multiplies on that unit. The back works on one word at a time and pops the next
// only when idle; the front takes words every cycle until its queue of QDEPTH entries is full.
// Reset: rst_n, synchronous, active low, empties queue and output.
module scalar_mod_order_alu #(
  parameter int QDEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  som_in_if.sink    in_s,
  som_out_if.source out_s
);

  logic              push;
  logic              full;
  logic              pop;
  logic              not_empty;
  som_pkg::q_entry_t push_data;
  som_pkg::q_entry_t head;

  som_front u_front (
    .in_s      (in_s),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  som_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  som_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .out_s     (out_s)
  );

endmodule
